// File: design/byte_budget_channel_queue_core_macros.svh
// Assertion macros for the byte-budget channel queue.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
// Defining ASSERT_OFF turns every check into nothing.
`ifndef BYTE_BUDGET_CHANNEL_QUEUE_CORE_MACROS_SVH
`define BYTE_BUDGET_CHANNEL_QUEUE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define BBCQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("bbcq assertion failed");
`define BBCQ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bbcq implication failed");
`else
`define BBCQ_ASSERT(label, prop)
`define BBCQ_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

// File: design/bbcq_pkg.sv
// Shared types and constants for the byte-budget channel queue.
// Depends on nothing; imported by byte_budget_channel_queue_core.
`default_nettype none

package bbcq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int LIMIT_W  = 5;
    localparam int SIZE_W   = 24;
    localparam int BYTES_W  = 31;
    localparam int HANDLE_W = 32;
    localparam int OCC_W    = 5;
    localparam int SEND_W   = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Commands.
    localparam logic [2:0] CMD_SEND            = 3'd0;
    localparam logic [2:0] CMD_RECEIVE         = 3'd1;
    localparam logic [2:0] CMD_SENDER_CLOSE    = 3'd2;
    localparam logic [2:0] CMD_RECEIVER_CLOSE  = 3'd3;
    localparam logic [2:0] CMD_ATTACH_RECEIVER = 3'd4;
    localparam logic [2:0] CMD_ADD_SENDER      = 3'd5;
    localparam logic [2:0] CMD_DROP_SENDER     = 3'd6;
    localparam logic [2:0] CMD_DROP_RECEIVER   = 3'd7;

    // Outcomes.
    localparam logic [2:0] OUT_OK          = 3'd0;
    localparam logic [2:0] OUT_FULL_EMPTY  = 3'd1;
    localparam logic [2:0] OUT_CLOSED      = 3'd2;
    localparam logic [2:0] OUT_TOO_LARGE   = 3'd3;
    localparam logic [2:0] OUT_OVER_BUDGET = 3'd4;
    localparam logic [2:0] OUT_WAIT        = 3'd5;

    // Register indexes (word address bits).
    localparam logic [1:0] REG_SLOT_LIMIT      = 2'd0;
    localparam logic [1:0] REG_LARGEST_MESSAGE = 2'd1;
    localparam logic [1:0] REG_BYTE_BUDGET     = 2'd2;

    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST      = LIMIT_W'(16);
    localparam logic [SIZE_W-1:0]  LARGEST_MESSAGE_RST = {SIZE_W{1'b1}};
    localparam logic [BYTES_W-1:0] BYTE_BUDGET_RST     = {BYTES_W{1'b1}};

    typedef struct packed {
        logic [2:0]          command;
        logic                wait_mode;
        logic [HANDLE_W-1:0] message_handle;
        logic [SIZE_W-1:0]   message_size;
    } t_in_item;

    typedef struct packed {
        logic [2:0]          outcome;
        logic [HANDLE_W-1:0] dequeued_handle;
        logic [SIZE_W-1:0]   dequeued_size;
        logic [OCC_W-1:0]    occupancy;
        logic                closed_flag;
    } t_out_item;

endpackage

`default_nettype wire

// File: design/byte_budget_channel_queue_core.sv
// Top level of the byte-budget channel queue: descriptor ring, counters and APB registers.
// Depends on bbcq_pkg and byte_budget_channel_queue_core_macros.svh.
`default_nettype none

// A command item is taken at any clock edge where start is high; busy is never raised, so
// one command per clock is sustained. Its result appears on o_result, marked by o_done
// high for a single cycle, in the cycle after acceptance: the single register stage that
// updates the queue state sets this. The receiver cannot stall and must take each result
// as it comes. Registers must be written over the APB port only while no command is in
// flight; the block itself does not enforce this. pready is always high.
module byte_budget_channel_queue_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire bbcq_pkg::t_in_item      i_item,
    output logic                         o_done,
    output bbcq_pkg::t_out_item          o_result,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [bbcq_pkg::ADDR_W-1:0]   paddr,
    input  wire [bbcq_pkg::DATA_W-1:0]   pwdata,
    output logic [bbcq_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import bbcq_pkg::*;

`include "byte_budget_channel_queue_core_macros.svh"

    logic [LIMIT_W-1:0]  r_slot_limit;
    logic [SIZE_W-1:0]   r_largest;
    logic [BYTES_W-1:0]  r_budget;

    logic [HANDLE_W-1:0] r_handles [QUEUE_DEPTH];
    logic [SIZE_W-1:0]   r_sizes   [QUEUE_DEPTH];

    logic [PTR_W-1:0]    r_rd_ptr,  n_rd_ptr;
    logic [PTR_W-1:0]    r_wr_ptr,  n_wr_ptr;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [BYTES_W-1:0]  r_bytes,   n_bytes;
    logic [SEND_W-1:0]   r_senders, n_senders;
    logic                r_rx,      n_rx;
    logic                r_shut,    n_shut;
    logic                r_done;
    t_out_item           r_result,  n_result;

    logic                accept;
    logic                do_write;
    logic [CNT_W-1:0]    ring;
    logic                full;
    logic                fits;
    logic [BYTES_W-1:0]  size_ext;
    logic [BYTES_W-1:0]  got_ext;
    logic [HANDLE_W-1:0] got_handle;
    logic [SIZE_W-1:0]   got_size;
    logic [CNT_W-1:0]    wr_inc;
    logic [CNT_W-1:0]    rd_inc;
    logic                cfg_write;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;

    // Out-of-range slot limits are clamped to a usable ring length.
    always_comb begin
        if (r_slot_limit == '0) begin
            ring = CNT_W'(1);
        end else if (CNT_W'(r_slot_limit) > CNT_W'(QUEUE_DEPTH)) begin
            ring = CNT_W'(QUEUE_DEPTH);
        end else begin
            ring = CNT_W'(r_slot_limit);
        end
    end

    assign full     = r_count >= ring;
    assign size_ext = BYTES_W'(i_item.message_size);
    assign fits     = (r_bytes <= r_budget) && (size_ext <= (r_budget - r_bytes));
    assign wr_inc   = CNT_W'(r_wr_ptr) + CNT_W'(1);
    assign rd_inc   = CNT_W'(r_rd_ptr) + CNT_W'(1);
    assign got_handle = r_handles[r_rd_ptr];
    assign got_size   = r_sizes[r_rd_ptr];
    assign got_ext    = BYTES_W'(got_size);

    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_bytes   = r_bytes;
        n_senders = r_senders;
        n_rx      = r_rx;
        n_shut    = r_shut;
        do_write  = 1'b0;
        n_result  = '0;
        n_result.outcome = OUT_OK;

        unique case (i_item.command)
            CMD_SEND: begin
                if (i_item.message_size > r_largest) begin
                    n_result.outcome = OUT_TOO_LARGE;
                end else if (i_item.wait_mode && !r_shut && r_rx && (full || !fits)) begin
                    n_result.outcome = OUT_WAIT;
                end else if (r_shut || !r_rx) begin
                    n_result.outcome = OUT_CLOSED;
                end else if (full) begin
                    n_result.outcome = OUT_FULL_EMPTY;
                end else if (!fits) begin
                    n_result.outcome = OUT_OVER_BUDGET;
                end else begin
                    do_write = 1'b1;
                    n_wr_ptr = (wr_inc >= ring) ? '0 : wr_inc[PTR_W-1:0];
                    n_count  = r_count + CNT_W'(1);
                    n_bytes  = r_bytes + size_ext;
                end
            end
            CMD_RECEIVE: begin
                if (r_count == '0) begin
                    if (i_item.wait_mode && !r_shut) begin
                        n_result.outcome = OUT_WAIT;
                    end else if (r_shut) begin
                        n_result.outcome = OUT_CLOSED;
                    end else begin
                        n_result.outcome = OUT_FULL_EMPTY;
                    end
                end else begin
                    n_result.dequeued_handle = got_handle;
                    n_result.dequeued_size   = got_size;
                    n_rd_ptr = (rd_inc >= ring) ? '0 : rd_inc[PTR_W-1:0];
                    n_count  = r_count - CNT_W'(1);
                    // The byte count floors at zero rather than wrapping.
                    n_bytes  = (got_ext > r_bytes) ? '0 : r_bytes - got_ext;
                end
            end
            CMD_SENDER_CLOSE: begin
                n_shut = 1'b1;
            end
            CMD_RECEIVER_CLOSE: begin
                n_shut = 1'b1;
                n_rx   = 1'b0;
            end
            CMD_ATTACH_RECEIVER: begin
                n_rx = 1'b1;
            end
            CMD_ADD_SENDER: begin
                if (r_senders != {SEND_W{1'b1}}) begin
                    n_senders = r_senders + SEND_W'(1);
                end
            end
            CMD_DROP_SENDER: begin
                if (r_senders != '0) begin
                    n_senders = r_senders - SEND_W'(1);
                    if (r_senders == SEND_W'(1)) begin
                        n_shut = 1'b1;
                    end
                end
            end
            CMD_DROP_RECEIVER: begin
                if (r_rx) begin
                    n_rx   = 1'b0;
                    n_shut = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_result.occupancy   = OCC_W'(n_count);
        n_result.closed_flag = n_shut;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_bytes   <= '0;
            r_senders <= SEND_W'(1);
            r_rx      <= 1'b0;
            r_shut    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_rd_ptr  <= n_rd_ptr;
                r_wr_ptr  <= n_wr_ptr;
                r_count   <= n_count;
                r_bytes   <= n_bytes;
                r_senders <= n_senders;
                r_rx      <= n_rx;
                r_shut    <= n_shut;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
        if (accept && do_write) begin
            r_handles[r_wr_ptr] <= i_item.message_handle;
            r_sizes[r_wr_ptr]   <= i_item.message_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= SLOT_LIMIT_RST;
            r_largest    <= LARGEST_MESSAGE_RST;
            r_budget     <= BYTE_BUDGET_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_SLOT_LIMIT:      r_slot_limit <= pwdata[LIMIT_W-1:0];
                REG_LARGEST_MESSAGE: r_largest    <= pwdata[SIZE_W-1:0];
                REG_BYTE_BUDGET:     r_budget     <= pwdata[BYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SLOT_LIMIT:      prdata = DATA_W'(r_slot_limit);
            REG_LARGEST_MESSAGE: prdata = DATA_W'(r_largest);
            REG_BYTE_BUDGET:     prdata = DATA_W'(r_budget);
            default:             prdata = '0;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `BBCQ_ASSERT(a_done_follows_accept, accept |=> o_done)
    `BBCQ_ASSERT(a_count_in_range, r_count <= CNT_W'(QUEUE_DEPTH))
    `BBCQ_ASSERT_IMPLY(a_occ_matches_count, o_done, o_result.occupancy == OCC_W'(r_count))
    `BBCQ_ASSERT_IMPLY(a_fail_keeps_count, o_done && o_result.outcome != OUT_OK, $stable(r_count))
    `BBCQ_ASSERT_IMPLY(a_wait_keeps_ptrs, o_done && o_result.outcome == OUT_WAIT,
                       $stable(r_wr_ptr) && $stable(r_rd_ptr))
    `BBCQ_ASSERT(a_shut_sticky, r_shut |=> r_shut)

endmodule

`default_nettype wire
